@@ rtl/core/per_host_syn_flood_guard_assert.svh @@
// Assertion macros for the per-host SYN flood guard
`ifndef PER_HOST_SYN_FLOOD_GUARD_ASSERT_SVH
`define PER_HOST_SYN_FLOOD_GUARD_ASSERT_SVH

`ifndef SYNTHESIS
`define SFG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfg assertion failed");
`define SFG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sfg assertion failed");
`else
`define SFG_ASSERT(lbl, prop)
`define SFG_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/core/sfg_pkg.sv @@
// Shared types and constants for the per-host SYN flood guard
package sfg_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned TmoW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT   = 2'd1;

  localparam logic [TmoW-1:0]   TIMEOUT_RST = 16'd30;
  localparam logic [CountW-1:0] LIMIT_RST   = 8'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0] address;
    logic             syn;
    logic             ack;
    logic [TimeW-1:0] now;
  } pkt_t;

  typedef struct packed {
    logic match_en;
    logic update_en;
    logic any_hit;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic match;
    logic drop;
  } cell_sts_t;

endpackage

@@ rtl/core/per_host_syn_flood_guard.sv @@
// Top level of the per-host SYN flood guard: control, config and cell row
//
// Usage:
//   Input: drive in_* with one TCP header and pulse start while busy is low;
//   the header is taken at that edge. Busy then stays high through ST_MATCH and ST_UPDATE.
//   Output: out_valid is registered from ST_UPDATE and is
//   high for exactly one cycle, with out_drop (1 = drop) and out_untracked
//   (1 = table full, host not tracked). The receiver cannot stall; every
//   result must be taken in its one cycle.
//   Processing: a new header is accepted only when busy is low. ST_MATCH
//   compares the address against every entry of the cell row in parallel;
//   ST_UPDATE lets the single matching cell, or the first free cell on a
//   miss, update itself and reports its verdict.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 is the
//   timeout in seconds, 1 is the SYN limit; other indexes are ignored.
//   cfg_ready is always high; write only while the block is idle.
//   Reset: rst_n low clears all entries, the control state and sets the
//   timeout to 30 and the limit to 5. No clearing pass is needed.
//   Entries never expire; a claimed slot is held until reset.
module per_host_syn_flood_guard #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sfg_pkg::AddrW-1:0]      in_source_address,
  input  logic                           in_syn_bit,
  input  logic                           in_ack_bit,
  input  logic [sfg_pkg::TimeW-1:0]      in_now_seconds,
  output logic                           out_valid,
  output logic                           out_drop,
  output logic                           out_untracked,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [sfg_pkg::CfgDataW-1:0]   cfg_data
);
  import sfg_pkg::*;

  `include "per_host_syn_flood_guard_assert.svh"

  state_t            state_r, state_nxt;
  pkt_t              pkt_r;
  logic [TmoW-1:0]   timeout_r;
  logic [CountW-1:0] limit_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic              out_untracked_r, out_untracked_nxt;
  logic              accept;

  cell_ctl_t                ctl;
  cell_sts_t                sts [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] drop_vec;
  logic [TABLE_ENTRIES:0]   chain;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  genvar g;
  assign chain[0] = 1'b1;
  for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    sfg_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .pkt        (pkt_r),
      .ctl        (ctl),
      .timeout    (timeout_r),
      .limit      (limit_r),
      .prev_valid (chain[g]),
      .sts        (sts[g])
    );
    assign valid_vec[g] = sts[g].valid;
    assign match_vec[g] = sts[g].match;
    assign drop_vec[g]  = sts[g].drop;
    assign chain[g+1]   = sts[g].valid;
  end

  always_comb begin
    state_nxt         = state_r;
    busy              = (state_r != ST_IDLE);
    ctl.match_en      = 1'b0;
    ctl.update_en     = 1'b0;
    ctl.any_hit       = |match_vec;
    out_valid_nxt     = 1'b0;
    out_drop_nxt      = out_drop_r;
    out_untracked_nxt = out_untracked_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        ctl.match_en = 1'b1;
        state_nxt    = ST_UPDATE;
      end
      ST_UPDATE: begin
        ctl.update_en     = 1'b1;
        out_valid_nxt     = 1'b1;
        out_drop_nxt      = |drop_vec;
        out_untracked_nxt = !ctl.any_hit && valid_vec[TABLE_ENTRIES-1];
        state_nxt         = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      limit_r     <= LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_r <= cfg_data[TmoW-1:0];
          CFG_LIMIT:   limit_r   <= cfg_data[CountW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pkt_r.address <= in_source_address;
      pkt_r.syn     <= in_syn_bit;
      pkt_r.ack     <= in_ack_bit;
      pkt_r.now     <= in_now_seconds;
    end
    out_drop_r      <= out_drop_nxt;
    out_untracked_r <= out_untracked_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_drop      = out_drop_r;
  assign out_untracked = out_untracked_r;

  `SFG_ASSERT(a_out_after_update, out_valid |-> $past(state_r == ST_UPDATE))
  `SFG_ASSERT(a_unique_hit, (state_r == ST_UPDATE) |-> $onehot0(match_vec))
  `SFG_ASSERT(a_single_writer, $onehot0(drop_vec))
  `SFG_ASSERT(a_untracked_kept, out_valid |-> !(out_drop && out_untracked))
  `SFG_ASSERT(a_accept_busy, accept |=> (busy && state_r == ST_MATCH))
  `SFG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && !busy))

endmodule

@@ rtl/core/sfg_cell.sv @@
// One tracked-host entry: address compare, count and stamp update
module sfg_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfg_pkg::pkt_t                 pkt,
  input  sfg_pkg::cell_ctl_t            ctl,
  input  logic [sfg_pkg::TmoW-1:0]      timeout,
  input  logic [sfg_pkg::CountW-1:0]    limit,
  input  logic                          prev_valid,
  output sfg_pkg::cell_sts_t            sts
);
  import sfg_pkg::*;

  logic              valid_r, valid_nxt;
  logic              match_r, match_nxt;
  logic [AddrW-1:0]  addr_r;
  logic [CountW-1:0] cnt_r, cnt_nxt;
  logic [TimeW-1:0]  stamp_r, stamp_nxt;

  logic              ins;
  logic              act;
  logic              over;
  logic              expire;
  logic [CountW-1:0] base_cnt;
  logic [CountW-1:0] cnt_a;
  logic [CountW:0]   sum;
  logic [CountW-1:0] cnt_new;
  logic [TimeW-1:0]  base_stamp;
  logic [TimeW-1:0]  elapsed;

  always_comb begin
    ins        = !ctl.any_hit && !valid_r && prev_valid;
    act        = ctl.update_en && (match_r || ins);
    base_cnt   = match_r ? cnt_r : '0;
    base_stamp = match_r ? stamp_r : pkt.now;
    over       = (base_cnt >= limit);
    elapsed    = pkt.now - base_stamp;
    expire     = (elapsed > {{(TimeW-TmoW){1'b0}}, timeout});
    cnt_a      = expire ? '0 : base_cnt;
    sum        = {1'b0, cnt_a} + {{CountW{1'b0}}, pkt.syn};
    cnt_new    = (sum >= {{CountW{1'b0}}, pkt.ack})
                 ? sum[CountW-1:0] - {{(CountW-1){1'b0}}, pkt.ack} : '0;

    valid_nxt = valid_r || act;
    match_nxt = ctl.match_en ? (valid_r && (addr_r == pkt.address)) : match_r;
    cnt_nxt   = cnt_r;
    stamp_nxt = stamp_r;
    if (act) begin
      cnt_nxt   = over ? base_cnt : cnt_new;
      stamp_nxt = (!over && expire) ? pkt.now : base_stamp;
    end

    sts.valid = valid_r;
    sts.match = match_r;
    sts.drop  = act && over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (act) begin
      addr_r <= pkt.address;
    end
    cnt_r   <= cnt_nxt;
    stamp_r <= stamp_nxt;
  end

endmodule
